// ===== design/vwl_pkg.sv =====
// ----------------------------------------------------------------------------
// vwl_pkg
// Shared types and constants of the per-list VLAN whitelist table.
// ----------------------------------------------------------------------------
package vwl_pkg;

    localparam int LISTS        = 128;
    localparam int SLOTS        = 8;

    localparam int VLAN_W       = 12;
    localparam int LIST_W       = 7;
    localparam int STATUS_W     = 2;
    localparam int SLOT_FIELD_W = 3;
    // wide enough to hold any list count in range, LISTS itself included
    localparam int LIST_EXT_W   = 11;

    localparam int ROW_W  = (LISTS > 1) ? $clog2(LISTS) : 1;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_DEL = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd3;

    typedef struct packed {
        logic              cmd;
        logic [LIST_W-1:0] list_index;
        logic [VLAN_W-1:0] vlan_id;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [SLOT_FIELD_W-1:0] slot;
    } rsp_t;

    // one list: a valid bit and an id per slot
    typedef struct packed {
        logic [SLOTS-1:0]             valid;
        logic [SLOTS-1:0][VLAN_W-1:0] vlan;
    } row_t;

    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [ROW_W-1:0] addr;
    } mem_req_t;

    // slot number as carried in the result field: low bits, zero-extended
    function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W+SLOT_FIELD_W-1:0] ext;
        begin
            ext = {{SLOT_FIELD_W{1'b0}}, idx};
            return ext[SLOT_FIELD_W-1:0];
        end
    endfunction

endpackage

// ===== design/per_list_vlan_whitelist_table.sv =====
// ----------------------------------------------------------------------------
// per_list_vlan_whitelist_table
// VLAN whitelist per function list: add an id to the lowest free slot or
// delete it, refusing duplicates, full lists and absent ids.
// ----------------------------------------------------------------------------
//  channel   ports                     direction  timing
//  request   start, busy, req          in         taken when start && !busy
//  result    done, rsp                 out        one cycle strobe, no stall
//
//  For each request the list's row is read from the row memory at the
//  accepting edge, and the next edge searches it, writes it back and
//  registers the result, which shows on rsp together with done.
//  A new request may be taken in the cycle the result is shown.
//  After reset the row memory is swept empty, one row a cycle; busy stays
//  high during the sweep.
//  The receiver cannot stall: done is a single-cycle strobe.
// ----------------------------------------------------------------------------
module per_list_vlan_whitelist_table (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  vwl_pkg::req_t req,
    output logic          done,
    output vwl_pkg::rsp_t rsp
);
    import vwl_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EVAL = 1'b1;

    logic     state_reg;
    logic     state_next;
    req_t     req_reg;
    rsp_t     rsp_reg;
    rsp_t     rsp_next;
    logic     done_reg;
    logic     done_next;

    logic     clearing;
    logic     accept;
    mem_req_t mem_req;
    row_t     rd_row;
    row_t     wr_row;

    logic [LIST_EXT_W-1:0] list_ext;
    logic                  in_range;
    logic                  hit_any;
    logic [SLOT_W-1:0]     hit_idx;
    logic                  free_any;
    logic [SLOT_W-1:0]     free_idx;

    vwl_row_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .mem_req  (mem_req),
        .wr_row   (wr_row),
        .rd_row   (rd_row),
        .clearing (clearing)
    );

    assign busy   = clearing || (state_reg != S_IDLE);
    assign accept = start && !busy;

    // the request's row address, extended so any list count compares cleanly
    assign list_ext = (state_reg == S_IDLE) ? LIST_EXT_W'(req.list_index)
                                            : LIST_EXT_W'(req_reg.list_index);
    assign in_range = list_ext < LIST_EXT_W'(LISTS);

    // search the row: lowest valid match and lowest free slot
    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (rd_row.valid[s] && (rd_row.vlan[s] == req_reg.vlan_id))
            begin
                hit_any = 1'b1;
                hit_idx = SLOT_W'(s);
            end
            if (!rd_row.valid[s])
            begin
                free_any = 1'b1;
                free_idx = SLOT_W'(s);
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        done_next        = 1'b0;
        rsp_next         = rsp_reg;
        wr_row           = rd_row;
        mem_req.rd_en    = accept;
        mem_req.wr_en    = 1'b0;
        mem_req.addr     = list_ext[ROW_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next      = S_IDLE;
                done_next       = 1'b1;
                rsp_next.slot   = '0;
                if (!in_range)
                begin
                    // list beyond the table: refuse, change nothing
                    rsp_next.status = (req_reg.cmd == CMD_DEL) ? ST_ABSENT : ST_FULL;
                end
                else if (req_reg.cmd == CMD_DEL)
                begin
                    if (hit_any)
                    begin
                        wr_row.valid[hit_idx] = 1'b0;
                        wr_row.vlan[hit_idx]  = '0;
                        mem_req.wr_en         = 1'b1;
                        rsp_next.status       = ST_DONE;
                        rsp_next.slot         = slot_field(hit_idx);
                    end
                    else
                    begin
                        rsp_next.status = ST_ABSENT;
                    end
                end
                else if (hit_any)
                begin
                    rsp_next.status = ST_DUP;
                end
                else if (free_any)
                begin
                    wr_row.valid[free_idx] = 1'b1;
                    wr_row.vlan[free_idx]  = req_reg.vlan_id;
                    mem_req.wr_en          = 1'b1;
                    rsp_next.status        = ST_DONE;
                    rsp_next.slot          = slot_field(free_idx);
                end
                else
                begin
                    rsp_next.status = ST_FULL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // payload: capture the request, hold the result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // one result per request, never two in a row
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // an accepted request always leads to a result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("request produced no result");

    // refused requests report slot zero
    a_refused_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status != ST_DONE)) |-> (rsp.slot == '0))
        else $error("refused request carries a slot number");

    // the row is only written back while a request is evaluated
    a_write_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> ((state_reg == S_EVAL) && !clearing))
        else $error("row write outside evaluation");

endmodule

// ===== design/vwl_row_store.sv =====
// ----------------------------------------------------------------------------
// vwl_row_store
// One row per list in a synchronous memory with a registered read.
// Sweeps all rows to empty after reset.
// ----------------------------------------------------------------------------
module vwl_row_store (
    input  logic              clk,
    input  logic              rst_n,
    input  vwl_pkg::mem_req_t mem_req,
    input  vwl_pkg::row_t     wr_row,
    output vwl_pkg::row_t     rd_row,
    output logic              clearing
);
    import vwl_pkg::*;

    row_t             row_mem [LISTS];
    row_t             rd_row_reg;
    logic [ROW_W-1:0] clr_reg;
    logic [ROW_W-1:0] clr_next;
    logic             clearing_reg;
    logic             clearing_next;

    logic             wr_en;
    logic [ROW_W-1:0] wr_addr;
    row_t             wr_data;

    // advance the sweep over all rows; clearing holds off requests while it runs
    always_comb
    begin
        clr_next      = clr_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_next = clr_reg + 1'b1;
            if (clr_reg == ROW_W'(LISTS - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_reg      <= clr_next;
            clearing_reg <= clearing_next;
        end
    end

    assign wr_en   = clearing_reg || mem_req.wr_en;
    assign wr_addr = clearing_reg ? clr_reg : mem_req.addr;
    assign wr_data = clearing_reg ? row_t'('0) : wr_row;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[wr_addr] <= wr_data;
        end
        if (mem_req.rd_en)
        begin
            rd_row_reg <= row_mem[mem_req.addr];
        end
    end

    assign rd_row   = rd_row_reg;
    assign clearing = clearing_reg;

endmodule
